FILE: src/ukrt_pkg.sv
// Shared types and constants for the unique key record table.
// No dependencies; every other file takes names from here by scope.
package ukrt_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned KeyBitsDef    = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned GRADE_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 3'd0,
    ST_FULL   = 3'd1,
    ST_EXISTS = 3'd2,
    ST_ABSENT = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_APPLY = 4'b1000
  } state_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cmp;
    logic scan;
    logic shift;
    logic write;
  } cell_ctrl_t;

endpackage

FILE: src/ukrt_if.sv
// Request and response channel interfaces (valid/ready) of the record table.
// Depends on ukrt_pkg.
interface ukrt_req_if #(
  parameter int unsigned KEY_BITS = ukrt_pkg::KeyBitsDef
);
  logic                         valid;
  logic                         ready;
  logic [ukrt_pkg::CMD_W-1:0]   command;
  logic [KEY_BITS-1:0]          record_key;
  logic [ukrt_pkg::AGE_W-1:0]   record_age;
  logic [ukrt_pkg::GRADE_W-1:0] record_grade;

  modport source (output valid, command, record_key, record_age, record_grade,
                  input ready);
  modport sink   (input valid, command, record_key, record_age, record_grade,
                  output ready);
endinterface

interface ukrt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ukrt_pkg::STATUS_W-1:0] status;
  logic [ukrt_pkg::LIMIT_W-1:0]  entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);
endinterface

FILE: src/unique_key_record_table_unit.sv
// Steps from request to response: compare, match ripple through the cell
// chain one slot a cycle, apply (held while the previous response is unread).
// A new request is taken only once the previous one has been applied.
// A new request is taken while the previous response still waits.
// Reset: count zero, entry_limit 16, no request in flight; slots undefined.
module unique_key_record_table_unit #(
  parameter int unsigned TABLE_DEPTH = ukrt_pkg::TableDepthDef,
  parameter int unsigned KEY_BITS    = ukrt_pkg::KeyBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ukrt_pkg::LIMIT_W-1:0] cfg_wdata_i,
  ukrt_req_if.sink                    req_i,
  ukrt_rsp_if.source                  rsp_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned W     = (CNT_W > ukrt_pkg::LIMIT_W) ? CNT_W : ukrt_pkg::LIMIT_W;
  localparam logic [CNT_W-1:0] ScanLast = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DepthC   = CNT_W'(TABLE_DEPTH);

  ukrt_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ukrt_pkg::LIMIT_W-1:0] limit_q;

  logic [ukrt_pkg::CMD_W-1:0]   cmd_q;
  logic [KEY_BITS-1:0]          key_q;
  logic [ukrt_pkg::AGE_W-1:0]   age_q;
  logic [ukrt_pkg::GRADE_W-1:0] grade_q;

  logic                          rsp_valid_q, rsp_valid_d;
  logic [ukrt_pkg::STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [ukrt_pkg::LIMIT_W-1:0]  rsp_count_q, rsp_count_d;

  ukrt_pkg::cell_ctrl_t ctrl;

  logic [KEY_BITS-1:0]          cell_key   [TABLE_DEPTH];
  logic [ukrt_pkg::AGE_W-1:0]   cell_age   [TABLE_DEPTH];
  logic [ukrt_pkg::GRADE_W-1:0] cell_grade [TABLE_DEPTH];
  logic                         cell_kill  [TABLE_DEPTH];

  logic          req_fire, slot_free, found, full;
  logic [W-1:0]  count_w, limit_w, count_next_w;

  assign req_fire  = req_i.valid && req_i.ready;
  assign slot_free = !rsp_valid_q || rsp_o.ready;
  assign found     = cell_kill[TABLE_DEPTH-1];
  assign count_w   = W'(count_q);
  assign limit_w   = W'(limit_q);
  assign full      = (count_w >= limit_w) || (count_q == DepthC);

  assign req_i.ready       = (state_q == ukrt_pkg::S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    count_d      = count_q;
    count_next_w = W'(count_q);
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    ctrl         = '0;
    case (state_q)
      ukrt_pkg::S_IDLE: begin
        if (req_fire) begin
          state_d = ukrt_pkg::S_CMP;
        end
      end
      ukrt_pkg::S_CMP: begin
        ctrl.cmp = 1'b1;
        scan_d   = '0;
        state_d  = ukrt_pkg::S_SCAN;
      end
      ukrt_pkg::S_SCAN: begin
        ctrl.scan = 1'b1;
        scan_d    = scan_q + 1'b1;
        if (scan_q == ScanLast) begin
          state_d = ukrt_pkg::S_APPLY;
        end
      end
      ukrt_pkg::S_APPLY: begin
        if (slot_free) begin
          case (cmd_q)
            ukrt_pkg::CMD_INSERT: begin
              if (full) begin
                rsp_status_d = ukrt_pkg::ST_FULL;
              end else if (found) begin
                rsp_status_d = ukrt_pkg::ST_EXISTS;
              end else begin
                rsp_status_d = ukrt_pkg::ST_DONE;
                ctrl.write   = 1'b1;
                count_d      = count_q + 1'b1;
              end
            end
            ukrt_pkg::CMD_DELETE: begin
              if (count_q == '0) begin
                rsp_status_d = ukrt_pkg::ST_EMPTY;
              end else if (!found) begin
                rsp_status_d = ukrt_pkg::ST_ABSENT;
              end else begin
                rsp_status_d = ukrt_pkg::ST_DONE;
                ctrl.shift   = 1'b1;
                count_d      = count_q - 1'b1;
              end
            end
            default: begin
              rsp_status_d = found ? ukrt_pkg::ST_DONE : ukrt_pkg::ST_ABSENT;
            end
          endcase
          count_next_w = W'(count_d);
          rsp_valid_d  = 1'b1;
          rsp_count_d  = count_next_w[ukrt_pkg::LIMIT_W-1:0];
          state_d      = ukrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ukrt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ukrt_pkg::S_IDLE;
      scan_q      <= '0;
      count_q     <= '0;
      limit_q     <= ukrt_pkg::LIMIT_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_status_q <= rsp_status_d;
    rsp_count_q  <= rsp_count_d;
    if (req_fire) begin
      cmd_q   <= req_i.command;
      key_q   <= req_i.record_key;
      age_q   <= req_i.record_age;
      grade_q <= req_i.record_grade;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                         kill_in;
    logic [KEY_BITS-1:0]          nb_key;
    logic [ukrt_pkg::AGE_W-1:0]   nb_age;
    logic [ukrt_pkg::GRADE_W-1:0] nb_grade;

    if (i == 0) begin : g_head
      assign kill_in = 1'b0;
    end else begin : g_link
      assign kill_in = cell_kill[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nb_key   = cell_key[i];
      assign nb_age   = cell_age[i];
      assign nb_grade = cell_grade[i];
    end else begin : g_next
      assign nb_key   = cell_key[i+1];
      assign nb_age   = cell_age[i+1];
      assign nb_grade = cell_grade[i+1];
    end

    ukrt_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .INDEX    (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .srch_key_i  (key_q),
      .new_age_i   (age_q),
      .new_grade_i (grade_q),
      .nb_key_i    (nb_key),
      .nb_age_i    (nb_age),
      .nb_grade_i  (nb_grade),
      .kill_i      (kill_in),
      .key_o       (cell_key[i]),
      .age_o       (cell_age[i]),
      .grade_o     (cell_grade[i]),
      .kill_o      (cell_kill[i])
    );
  end

endmodule

FILE: src/ukrt_cell.sv
// One table slot: holds a record, compares it against the search key and
// passes an any-match-so-far flag to the next slot. Depends on ukrt_pkg.
module ukrt_cell #(
  parameter int unsigned KEY_BITS = ukrt_pkg::KeyBitsDef,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned INDEX    = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ukrt_pkg::cell_ctrl_t         ctrl_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic [KEY_BITS-1:0]          srch_key_i,
  input  logic [ukrt_pkg::AGE_W-1:0]   new_age_i,
  input  logic [ukrt_pkg::GRADE_W-1:0] new_grade_i,
  input  logic [KEY_BITS-1:0]          nb_key_i,
  input  logic [ukrt_pkg::AGE_W-1:0]   nb_age_i,
  input  logic [ukrt_pkg::GRADE_W-1:0] nb_grade_i,
  input  logic                         kill_i,
  output logic [KEY_BITS-1:0]          key_o,
  output logic [ukrt_pkg::AGE_W-1:0]   age_o,
  output logic [ukrt_pkg::GRADE_W-1:0] grade_o,
  output logic                         kill_o
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

  logic [KEY_BITS-1:0]          key_q;
  logic [ukrt_pkg::AGE_W-1:0]   age_q;
  logic [ukrt_pkg::GRADE_W-1:0] grade_q;
  logic                         hit_q, hit_d;
  logic                         kill_q, kill_d;

  always_comb begin
    hit_d  = hit_q;
    kill_d = kill_q;
    if (ctrl_i.cmp) begin
      hit_d  = (key_q == srch_key_i) && (Idx < count_i);
      kill_d = 1'b0;
    end else if (ctrl_i.scan) begin
      kill_d = kill_i | hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      kill_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      kill_q <= kill_d;
    end
  end

  // record payload: insert at the fill position, shift down on delete
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write && (count_i == Idx)) begin
      key_q   <= srch_key_i;
      age_q   <= new_age_i;
      grade_q <= new_grade_i;
    end else if (ctrl_i.shift && kill_q) begin
      key_q   <= nb_key_i;
      age_q   <= nb_age_i;
      grade_q <= nb_grade_i;
    end
  end

  assign key_o   = key_q;
  assign age_o   = age_q;
  assign grade_o = grade_q;
  assign kill_o  = kill_q;

endmodule
